### hw/rtl/ohb_pkg.sv
package ohb_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] in_reading;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] out_reading;
        logic              last_of_dump;
        logic [CNT_W-1:0]  dump_count;
        logic              buffer_empty;
    } t_out;

    // shift moves every cell one place down the ring, load_new feeds the head
    // from the input instead of the tail
    typedef struct packed {
        logic shift;
        logic load_new;
    } t_chain_ctl;

endpackage

### hw/rtl/overwrite_oldest_history_buffer_core.sv
// channel  | direction | handshake             | payload
// in       | input     | i_in_valid/o_in_stall | i_in_data  (t_in)
// out      | output    | o_out_valid/i_out_stall | o_out_data (t_out)
// cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (buffer_size)
//
// an insert item is taken while no dump is busy, back to back, and shifts the cell ring
// a non-empty dump item rotates the 64-cell ring once around,
// emitting its dump_count items from the tail cell, one per cycle unless the output stalls
// an empty dump sets busy, then registers its one item once the output slot is free
// reset (synchronous, active low) clears the count and sets size to 64; cells are not cleared
// output stall freezes the ring rotation only while entries are being emitted
module overwrite_oldest_history_buffer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ohb_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ohb_pkg::t_out               o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ohb_pkg::CNT_W-1:0]   i_cfg_data
);

    ohb_pkg::t_chain_ctl         chain_ctl;
    logic [ohb_pkg::DATA_W-1:0]  cell_q [ohb_pkg::DEPTH];
    logic [ohb_pkg::DATA_W-1:0]  head_d;

    ohb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_tail      (cell_q[ohb_pkg::DEPTH-1]),
        .o_ctl       (chain_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // newest reading enters at cell 0; during a dump the tail wraps to the head
    assign head_d = chain_ctl.load_new ? i_in_data.in_reading : cell_q[ohb_pkg::DEPTH-1];

    for (genvar g = 0; g < ohb_pkg::DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            ohb_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (chain_ctl.shift),
                .i_d     (head_d),
                .o_q     (cell_q[g])
            );
        end else begin : g_body
            ohb_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (chain_ctl.shift),
                .i_d     (cell_q[g-1]),
                .o_q     (cell_q[g])
            );
        end
    end

`ifndef NO_ASSERTIONS
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.buffer_empty |->
            o_out_data.last_of_dump && (o_out_data.dump_count == '0)
            && (o_out_data.out_reading == '0))
        else $error("empty dump item malformed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.buffer_empty |->
            (o_out_data.dump_count != '0)
            && (o_out_data.dump_count <= ohb_pkg::CNT_W'(ohb_pkg::DEPTH)))
        else $error("dump count out of range");

    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_dump |-> o_in_stall)
        else $error("dump ended before its final item");
`endif

endmodule

### hw/rtl/ohb_cell.sv
module ohb_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [ohb_pkg::DATA_W-1:0]  i_d,
    output logic [ohb_pkg::DATA_W-1:0]  o_q
);

    logic [ohb_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_d;
        end
    end

    assign o_q = r_data;

endmodule

### hw/rtl/ohb_ctrl.sv
module ohb_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_action,
    output logic                        o_in_stall,
    input  logic                        i_cfg_valid,
    input  logic [ohb_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                        o_cfg_ready,
    input  logic [ohb_pkg::DATA_W-1:0]  i_tail,
    output ohb_pkg::t_chain_ctl         o_ctl,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ohb_pkg::t_out               o_out_data
);

    logic                       r_busy;
    logic [ohb_pkg::IDX_W-1:0]  r_step;
    logic [ohb_pkg::CNT_W-1:0]  r_count;
    logic [ohb_pkg::CNT_W-1:0]  r_size;
    logic                       r_out_valid;
    ohb_pkg::t_out              r_out;

    logic                       in_fire;
    logic                       ins;
    logic                       cfg_fire;
    logic                       slot_free;
    logic [ohb_pkg::CNT_W:0]    phase_sum;
    logic                       out_phase;
    logic                       rot;
    logic                       emit_data;
    logic                       emit_empty;
    logic                       step_last;
    logic [ohb_pkg::CNT_W-1:0]  n_size;

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign in_fire     = i_in_valid & ~r_busy;
    assign ins         = in_fire & (i_in_action == ohb_pkg::ACT_INSERT);
    assign cfg_fire    = i_cfg_valid & ~r_busy;
    assign slot_free   = ~r_out_valid | ~i_out_stall;

    // the oldest held entry reaches the tail cell once step + count hits the depth
    assign phase_sum = {2'b00, r_step} + {1'b0, r_count};
    assign out_phase = phase_sum >= (ohb_pkg::CNT_W+1)'(ohb_pkg::DEPTH);
    assign step_last = r_step == ohb_pkg::IDX_W'(ohb_pkg::DEPTH - 1);

    assign rot        = r_busy & (r_count != '0) & (~out_phase | slot_free);
    assign emit_data  = r_busy & (r_count != '0) & out_phase & slot_free;
    assign emit_empty = r_busy & (r_count == '0) & slot_free;

    assign o_ctl.shift    = ins | rot;
    assign o_ctl.load_new = ins;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = ohb_pkg::CNT_W'(1);
        end else if (i_cfg_data > ohb_pkg::CNT_W'(ohb_pkg::DEPTH)) begin
            n_size = ohb_pkg::CNT_W'(ohb_pkg::DEPTH);
        end else begin
            n_size = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_count     <= '0;
            r_size      <= ohb_pkg::CNT_W'(ohb_pkg::DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_size  <= n_size;
                r_count <= '0;
            end else if (ins && (r_count < r_size)) begin
                r_count <= r_count + 1'b1;
            end

            if (in_fire && (i_in_action == ohb_pkg::ACT_DUMP)) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (emit_empty) begin
                r_busy <= 1'b0;
            end else if (rot) begin
                r_step <= r_step + 1'b1;
                if (step_last) begin
                    r_busy <= 1'b0;
                end
            end

            if (emit_data || emit_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_empty) begin
            r_out.out_reading  <= '0;
            r_out.last_of_dump <= 1'b1;
            r_out.dump_count   <= '0;
            r_out.buffer_empty <= 1'b1;
        end else if (emit_data) begin
            r_out.out_reading  <= i_tail;
            r_out.last_of_dump <= step_last;
            r_out.dump_count   <= r_count;
            r_out.buffer_empty <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
